// File: hw/rtl/srpd_pkg.sv
// ----------------------------------------------------------------------------
// srpd_pkg
// Shared types and constants for the sparse random projection dot block.
// ----------------------------------------------------------------------------
`default_nettype none

package srpd_pkg;

  localparam int unsigned ACC_W  = 48;
  localparam int unsigned QDEPTH = 8;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [63:0] PAIR_PRIME = 64'd16777619;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_WEIGHT_MASK   = 2'd0,
    REG_COLUMN_SELECT = 2'd1,
    REG_HASH_SEED     = 2'd2,
    REG_INDEX_OFFSET  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic        we;
    cfg_reg_e    index;
    logic [63:0] data;
  } cfg_wr_t;

  // signed contribution of one feature, already zeroed or negated
  typedef struct packed {
    logic signed [ACC_W-1:0] value;
    logic                    last;
  } contrib_t;

  typedef struct packed {
    logic     valid;
    contrib_t item;
  } q_push_t;

  typedef struct packed {
    logic     nonempty;
    contrib_t head;
  } q_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/srpd_feat_if.sv
// ----------------------------------------------------------------------------
// srpd_feat_if
// Feature input channel: valid/ready handshake with one sparse feature item.
// ----------------------------------------------------------------------------
`default_nettype none

interface srpd_feat_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [31:0] value_a;
  logic [63:0]        index_a;
  logic signed [31:0] value_b;
  logic [63:0]        index_b;
  logic               last_item;

  modport source (output valid, op, value_a, index_a, value_b, index_b, last_item,
                  input ready);
  modport sink (input valid, op, value_a, index_a, value_b, index_b, last_item,
                output ready);
endinterface

`default_nettype wire

// File: hw/rtl/srpd_result_if.sv
// ----------------------------------------------------------------------------
// srpd_result_if
// Result channel: valid/ready handshake with one dot product per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface srpd_result_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] dot_sum;
  logic               saturated;

  modport source (output valid, dot_sum, saturated, input ready);
  modport sink (input valid, dot_sum, saturated, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/srpd_front.sv
// ----------------------------------------------------------------------------
// srpd_front
// Accepts features, forms the product and hashed index, classifies each
// feature as zero, plus or minus and pushes its contribution to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module srpd_front (
  input  wire logic              clk,
  input  wire logic              rst,
  srpd_feat_if.sink              feat,
  input  wire srpd_pkg::cfg_wr_t cfg,
  input  wire logic              pop,
  output srpd_pkg::q_push_t      push
);

  logic [63:0] weight_mask;
  logic [63:0] column_select;
  logic [63:0] hash_seed;
  logic [63:0] index_offset;

  // slots held by items in flight plus items in the queue
  logic [srpd_pkg::QCNT_W-1:0] occ;
  logic [srpd_pkg::QCNT_W-1:0] occ_next;
  logic                        accept;

  logic               v1, v2, v3, v4;
  logic               s1_op, s1_last;
  logic signed [63:0] s1_prod;
  logic signed [31:0] s1_va;
  logic [63:0]        s1_ia;
  logic [63:0]        s1_mix;

  logic                               s2_last;
  logic signed [srpd_pkg::ACC_W-1:0] s2_value;
  logic [63:0]                        s2_off;

  logic                               s3_last;
  logic signed [srpd_pkg::ACC_W-1:0] s3_value;
  logic [63:0]                        s3_idx;

  logic                               s4_last;
  logic signed [srpd_pkg::ACC_W-1:0] s4_value;
  logic                               s4_nz;
  logic [63:0]                        s4_idx2;

  logic signed [63:0]                 prod;
  logic [63:0]                        mix;
  logic signed [63:0]                 rnd;
  logic signed [srpd_pkg::ACC_W-1:0] value_sel;
  logic [63:0]                        index_sel;

  assign feat.ready = (occ != srpd_pkg::QCNT_W'(srpd_pkg::QDEPTH));
  assign accept     = feat.valid && feat.ready;

  always_comb begin
    occ_next = occ;
    if (accept && !pop) begin
      occ_next = occ + 1'b1;
    end else if (!accept && pop) begin
      occ_next = occ - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_mask   <= '0;
      column_select <= '0;
      hash_seed     <= '0;
      index_offset  <= '0;
    end else if (cfg.we) begin
      unique case (cfg.index)
        srpd_pkg::REG_WEIGHT_MASK:   weight_mask   <= cfg.data;
        srpd_pkg::REG_COLUMN_SELECT: column_select <= cfg.data;
        srpd_pkg::REG_HASH_SEED:     hash_seed     <= cfg.data;
        srpd_pkg::REG_INDEX_OFFSET:  index_offset  <= cfg.data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      v4  <= 1'b0;
    end else begin
      occ <= occ_next;
      v1  <= accept;
      v2  <= v1;
      v3  <= v2;
      v4  <= v3;
    end
  end

  // stage 1: product and prime-multiply scramble of the outer index
  assign prod = feat.value_a * feat.value_b;
  assign mix  = feat.index_b * srpd_pkg::PAIR_PRIME;

  always_ff @(posedge clk) begin
    s1_op   <= feat.op;
    s1_last <= feat.last_item;
    s1_prod <= prod;
    s1_va   <= feat.value_a;
    s1_ia   <= feat.index_a;
    s1_mix  <= mix;
  end

  // stage 2: for op, round to nearest, ties up, and combine indexes; apply offset
  assign rnd = s1_prod + 64'sd32768;

  always_comb begin
    if (s1_op) begin
      value_sel = rnd[63:16];
      index_sel = s1_ia ^ s1_mix;
    end else begin
      value_sel = {{(srpd_pkg::ACC_W-32){s1_va[31]}}, s1_va};
      index_sel = s1_ia;
    end
  end

  always_ff @(posedge clk) begin
    s2_last  <= s1_last;
    s2_value <= value_sel;
    s2_off   <= index_sel + index_offset;
  end

  // stage 3: mask and shift to the column
  always_ff @(posedge clk) begin
    s3_last  <= s2_last;
    s3_value <= s2_value;
    s3_idx   <= (s2_off & weight_mask) + column_select;
  end

  // stage 4: nonzero parity, seed the sign index
  always_ff @(posedge clk) begin
    s4_last  <= s3_last;
    s4_value <= s3_value;
    s4_nz    <= ^s3_idx;
    s4_idx2  <= s3_idx + hash_seed;
  end

  always_comb begin
    push.valid     = v4;
    push.item.last = s4_last;
    if (!s4_nz) begin
      push.item.value = '0;
    end else if (^s4_idx2) begin
      push.item.value = -s4_value;
    end else begin
      push.item.value = s4_value;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/srpd_queue.sv
// ----------------------------------------------------------------------------
// srpd_queue
// Short FIFO of signed contributions between the front and the accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module srpd_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire srpd_pkg::q_push_t push,
  input  wire logic              pop,
  output srpd_pkg::q_status_t    status
);

  srpd_pkg::contrib_t mem [srpd_pkg::QDEPTH];

  logic [srpd_pkg::QPTR_W-1:0] wr_ptr;
  logic [srpd_pkg::QPTR_W-1:0] rd_ptr;
  logic [srpd_pkg::QCNT_W-1:0] count;

  assign status.nonempty = (count != '0);
  assign status.head     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr] <= push.item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push.valid && !pop) begin
        count <= count + 1'b1;
      end else if (!push.valid && pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/srpd_back.sv
// ----------------------------------------------------------------------------
// srpd_back
// Saturating accumulator; emits the sum on the last feature and clears.
// ----------------------------------------------------------------------------
`default_nettype none

module srpd_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire srpd_pkg::q_status_t status,
  output logic                     pop,
  srpd_result_if.source            result
);

  logic signed [srpd_pkg::ACC_W-1:0] acc;
  logic                               sat_seen;
  logic                               out_valid;
  logic signed [srpd_pkg::ACC_W-1:0] out_sum;
  logic                               out_sat;

  logic signed [srpd_pkg::ACC_W:0]   sum;
  logic signed [srpd_pkg::ACC_W-1:0] clipped;
  logic                               clip;

  assign result.valid     = out_valid;
  assign result.dot_sum   = out_sum;
  assign result.saturated = out_sat;

  // a non-last item never needs the output register
  assign pop = status.nonempty &&
               (!status.head.last || !out_valid || result.ready);

  assign sum = {acc[srpd_pkg::ACC_W-1], acc} +
               {status.head.value[srpd_pkg::ACC_W-1], status.head.value};

  always_comb begin
    clip    = sum[srpd_pkg::ACC_W] != sum[srpd_pkg::ACC_W-1];
    clipped = sum[srpd_pkg::ACC_W-1:0];
    if (clip) begin
      clipped = sum[srpd_pkg::ACC_W] ? srpd_pkg::ACC_MIN : srpd_pkg::ACC_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      sat_seen  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop && status.head.last) begin
        acc       <= '0;
        sat_seen  <= 1'b0;
        out_valid <= 1'b1;
      end else begin
        if (pop) begin
          acc      <= clipped;
          sat_seen <= sat_seen | clip;
        end
        if (result.ready) begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && status.head.last) begin
      out_sum <= clipped;
      out_sat <= sat_seen | clip;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/sparse_random_projection_dot.sv
// ----------------------------------------------------------------------------
// sparse_random_projection_dot
// A last feature passes the four front stages and a queue entry, then its
// sum is registered at the output. Throughput: one feature per cycle unless
// the queue is full or a result is not taken, set by the single accumulate
// in the back end; the 8-entry queue covers the 4-stage front pipeline. Reset
// clears config registers, accumulator, saturation flag, queue, valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_random_projection_dot (
  input  wire logic        clk,
  input  wire logic        rst,
  srpd_feat_if.sink        feat,
  srpd_result_if.source    result,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  srpd_pkg::cfg_wr_t   cfg;
  srpd_pkg::q_push_t   push;
  srpd_pkg::q_status_t status;
  logic                pop;

  assign cfg.we    = cfg_we;
  assign cfg.index = srpd_pkg::cfg_reg_e'(cfg_index);
  assign cfg.data  = cfg_data;

  srpd_front u_front (
    .clk  (clk),
    .rst  (rst),
    .feat (feat),
    .cfg  (cfg),
    .pop  (pop),
    .push (push)
  );

  srpd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .pop    (pop),
    .status (status)
  );

  srpd_back u_back (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .pop    (pop),
    .result (result)
  );

endmodule

`default_nettype wire
